/* rtl/phpsf_pkg.sv */
// ----------------------------------------------------------------------------
// Packet classifier package
// Shared opcodes, verdict codes and protocol constants.
// ----------------------------------------------------------------------------
package phpsf_pkg;

  localparam int unsigned DefBlocklistEntries = 16;
  localparam int unsigned DefMaxFrameBytes    = 16383;
  localparam int unsigned DefRuleCount        = 2;

  typedef enum logic [1:0] {
    OP_BYTE   = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    OUT_ACCEPT = 2'd0,
    OUT_PASS   = 2'd1,
    OUT_BLOCK  = 2'd2,
    OUT_SIG    = 2'd3
  } outcome_e;

  localparam logic [1:0] REG_SIG0 = 2'd0;
  localparam logic [1:0] REG_ON0  = 2'd1;
  localparam logic [1:0] REG_SIG1 = 2'd2;
  localparam logic [1:0] REG_ON1  = 2'd3;

  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;
  localparam logic [15:0] DNS_PORT  = 16'd53;
  localparam logic [3:0]  MIN_IHL   = 4'd5;
  localparam int unsigned EthLen    = 14;
  localparam int unsigned MinIpFrame = 34;

  // Captured header state of the frame in progress.
  typedef struct packed {
    logic [3:0]  ihl;
    logic [3:0]  doff;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [63:0] head;
  } hdr_t;

endpackage

/* rtl/packet_header_parser_signature_filter.sv */
// ----------------------------------------------------------------------------
// Packet header parser and signature filter
// Frame bytes and blocklist commands in, one verdict word per frame out.
// ----------------------------------------------------------------------------
// One input word is accepted every cycle unless a stalled verdict has already
// filled the one-entry skid buffer. Frame bytes update the header capture
// registers; the byte marked as frame end is judged in the same cycle against
// the blocklist and signature rules, and the verdict word is registered.
// Blocklist commands take effect at once.
module packet_header_parser_signature_filter #(
  parameter int unsigned BLOCKLIST_ENTRIES = phpsf_pkg::DefBlocklistEntries,
  parameter int unsigned MAX_FRAME_BYTES   = phpsf_pkg::DefMaxFrameBytes,
  parameter int unsigned RULE_COUNT        = phpsf_pkg::DefRuleCount
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  frame_byte_i,
  input  logic        frame_end_i,
  input  logic [31:0] table_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  outcome_o,
  output logic        rule_index_o,
  output logic [31:0] src_address_o,
  output logic [31:0] dst_address_o,
  output logic [15:0] source_port_o,
  output logic [15:0] dest_port_o,
  output logic [7:0]  ip_protocol_o,
  output logic [63:0] matched_signature_o,
  output logic [63:0] payload_prefix_o
);
  import phpsf_pkg::*;

  typedef struct packed {
    logic [1:0]  outcome;
    logic        rule;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  proto;
    logic [63:0] sig;
    logic [63:0] snip;
  } res_t;

  logic [63:0] sig_q [2];
  logic [1:0]  on_q;
  logic        acc, take, last, hit;
  hdr_t        hdr;
  logic [16:0] len, l4, need, ps, avail;
  logic        need_ok;
  res_t        res;
  res_t        out_q, skid_q;
  logic        out_v_q, skid_v_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_q[0] <= '0;
      sig_q[1] <= '0;
      on_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SIG0: sig_q[0] <= cfg_data_i;
        REG_ON0:  on_q[0]  <= cfg_data_i[0];
        REG_SIG1: sig_q[1] <= cfg_data_i;
        REG_ON1:  on_q[1]  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = skid_v_q;
  assign acc  = in_valid_i && !in_stall_o;
  assign take = acc && (opcode_i == OP_BYTE);
  assign last = take && frame_end_i;

  phpsf_capture #(.MaxFrameBytes(MAX_FRAME_BYTES)) u_cap (
    .clk_i, .rst_ni, .take_i(take), .last_i(frame_end_i), .byte_i(frame_byte_i),
    .hdr_o(hdr), .len_o(len)
  );

  phpsf_blocklist #(.Entries(BLOCKLIST_ENTRIES)) u_bl (
    .clk_i, .rst_ni,
    .add_i(acc && opcode_i == OP_ADD), .remove_i(acc && opcode_i == OP_REMOVE),
    .addr_i(table_address_i), .lookup_i(hdr.src), .hit_o(hit)
  );

  // Verdict for the frame ending this cycle.
  always_comb begin
    res         = '0;
    res.outcome = OUT_PASS;
    l4 = 17'(EthLen) + {11'd0, hdr.ihl, 2'b00};
    need_ok = 1'b1;
    if (hdr.proto == PROTO_TCP) need = l4 + 17'd20;
    else if (hdr.proto == PROTO_UDP) need = l4 + ((hdr.dport == DNS_PORT) ? 17'd20 : 17'd8);
    else begin
      need    = '0;
      need_ok = 1'b0;
    end
    if (hdr.proto == PROTO_TCP)
      ps = l4 + {11'd0, ((hdr.doff < MIN_IHL) ? MIN_IHL : hdr.doff), 2'b00};
    else ps = need;
    avail = (len > ps) ? len - ps : '0;
    if (len >= 17'(MinIpFrame) && hdr.ihl >= MIN_IHL) begin
      if (hit) begin
        res.outcome = OUT_BLOCK;
        res.src = hdr.src;
        res.dst = hdr.dst;
        res.proto = hdr.proto;
      end else if (need_ok && len >= need) begin
        res.outcome = OUT_ACCEPT;
        res.src = hdr.src;
        res.dst = hdr.dst;
        res.proto = hdr.proto;
        res.sport = hdr.sport;
        res.dport = hdr.dport;
        if (avail >= 17'd4) begin
          if (on_q[0] && sig_q[0][63:32] == hdr.head[63:32]) begin
            res.outcome = OUT_SIG;
            res.sig  = sig_q[0];
            res.snip = hdr.head;
          end else if (RULE_COUNT > 1 && on_q[1] && sig_q[1][63:32] == hdr.head[63:32]) begin
            res.outcome = OUT_SIG;
            res.rule = 1'b1;
            res.sig  = sig_q[1];
            res.snip = hdr.head;
          end
        end
      end
    end
  end

  // Output register with skid stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (!out_v_q || !out_stall_i) begin
        out_v_q  <= skid_v_q || last;
        skid_v_q <= 1'b0;
      end else if (last) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || !out_stall_i) begin
      out_q <= skid_v_q ? skid_q : res;
    end else if (last) begin
      skid_q <= res;
    end
  end

  assign out_valid_o         = out_v_q;
  assign outcome_o           = out_q.outcome;
  assign rule_index_o        = out_q.rule;
  assign src_address_o       = out_q.src;
  assign dst_address_o       = out_q.dst;
  assign source_port_o       = out_q.sport;
  assign dest_port_o         = out_q.dport;
  assign ip_protocol_o       = out_q.proto;
  assign matched_signature_o = out_q.sig;
  assign payload_prefix_o    = out_q.snip;

  // The skid stage only fills behind a waiting result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid full with empty output");
  // A stalled result is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_stall_i |=> out_v_q && $stable(out_q))
    else $error("stalled result changed");
  // The matched signature is zero on anything but a signature verdict.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && outcome_o != OUT_SIG |-> matched_signature_o == '0)
    else $error("signature shown without match");

endmodule

/* rtl/phpsf_blocklist.sv */
// ----------------------------------------------------------------------------
// Packet classifier blocklist
// Source address table with add, remove, replacement pointer and lookup.
// ----------------------------------------------------------------------------
module phpsf_blocklist #(
  parameter int unsigned Entries = phpsf_pkg::DefBlocklistEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        add_i,
  input  logic        remove_i,
  input  logic [31:0] addr_i,
  input  logic [31:0] lookup_i,
  output logic        hit_o
);
  import phpsf_pkg::*;

  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1;

  logic [31:0]        entry_q [Entries];
  logic [Entries-1:0] valid_q, valid_d;
  logic [IdxW-1:0]    ptr_q, ptr_d;
  logic [Entries-1:0] match_add, match_look;
  logic               has_free;
  logic [IdxW-1:0]    free_idx, wr_idx;
  logic               wr_en;

  // Parallel compares against every valid entry.
  always_comb begin
    for (int i = 0; i < Entries; i++) begin
      match_add[i]  = valid_q[i] && (entry_q[i] == addr_i);
      match_look[i] = valid_q[i] && (entry_q[i] == lookup_i);
    end
  end
  assign hit_o = |match_look;

  // Lowest free slot.
  always_comb begin
    has_free = 1'b0;
    free_idx = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        has_free = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  // Slot choice and valid update.
  always_comb begin
    valid_d = valid_q;
    ptr_d   = ptr_q;
    wr_en   = 1'b0;
    wr_idx  = free_idx;
    if (add_i && !(|match_add)) begin
      wr_en = 1'b1;
      if (!has_free) begin
        wr_idx = ptr_q;
        ptr_d  = (32'(ptr_q) == Entries - 1) ? '0 : ptr_q + 1'b1;
      end
      valid_d[wr_idx] = 1'b1;
    end else if (remove_i) begin
      valid_d = valid_q & ~match_add;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ptr_q   <= '0;
    end else begin
      valid_q <= valid_d;
      ptr_q   <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q[wr_idx] <= addr_i;
    end
  end

  // The pointer only moves while the table is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ptr_q != $past(ptr_q)) |-> (&$past(valid_q)))
    else $error("replacement pointer moved with a free slot");
  // After an add the table holds at least one valid entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    add_i |=> |valid_q)
    else $error("add left the table empty");
  // A remove never creates a valid entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    remove_i && !add_i |=> (valid_q & ~$past(valid_q)) == '0)
    else $error("remove set a valid bit");

endmodule

/* rtl/phpsf_capture.sv */
// ----------------------------------------------------------------------------
// Packet classifier header capture
// Tracks byte position and captures header fields and payload head.
// ----------------------------------------------------------------------------
module phpsf_capture #(
  parameter int unsigned MaxFrameBytes = phpsf_pkg::DefMaxFrameBytes
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   take_i,
  input  logic                   last_i,
  input  logic [7:0]             byte_i,
  output phpsf_pkg::hdr_t        hdr_o,
  output logic [16:0]            len_o
);
  import phpsf_pkg::*;

  localparam int unsigned PosW = $clog2(MaxFrameBytes + 1);

  logic [PosW-1:0] pos_q, pos_d;
  hdr_t            hdr_q, hdr_d, hdr_n;
  logic [16:0]     p, l4, ps;
  logic [3:0]      tw;
  logic            has_ps;

  assign p = 17'(pos_q);

  // Per-byte field capture; the frame state clears after the last byte.
  always_comb begin
    hdr_n  = hdr_q;
    pos_d  = pos_q;
    l4     = 17'(EthLen) + {11'd0, hdr_q.ihl, 2'b00};
    tw     = (hdr_q.doff < MIN_IHL) ? MIN_IHL : hdr_q.doff;
    has_ps = 1'b1;
    if (hdr_q.proto == PROTO_TCP) begin
      ps = l4 + {11'd0, tw, 2'b00};
    end else if (hdr_q.proto == PROTO_UDP) begin
      ps = l4 + ((hdr_q.dport == DNS_PORT) ? 17'd20 : 17'd8);
    end else begin
      ps     = '0;
      has_ps = 1'b0;
    end
    if (take_i && (32'(pos_q) < MaxFrameBytes)) begin
      pos_d = pos_q + 1'b1;
      if (p == 17'd14) hdr_n.ihl = byte_i[3:0];
      else if (p == 17'd23) hdr_n.proto = byte_i;
      else if (p >= 17'd26 && p < 17'd30) hdr_n.src = {hdr_q.src[23:0], byte_i};
      else if (p >= 17'd30 && p < 17'd34) hdr_n.dst = {hdr_q.dst[23:0], byte_i};
      if (hdr_q.ihl >= MIN_IHL && p >= 17'(MinIpFrame)) begin
        if (p == l4 || p == l4 + 17'd1) hdr_n.sport = {hdr_q.sport[7:0], byte_i};
        else if (p == l4 + 17'd2 || p == l4 + 17'd3)
          hdr_n.dport = {hdr_q.dport[7:0], byte_i};
        else if (p == l4 + 17'd12 && hdr_q.proto == PROTO_TCP) hdr_n.doff = byte_i[7:4];
        if (has_ps && p >= ps && (p - ps) < 17'd8)
          hdr_n.head = hdr_q.head | ({56'd0, byte_i} << {(3'd7 - 3'(p - ps)), 3'b000});
      end
    end
    hdr_d = hdr_n;
    if (take_i && last_i) begin
      hdr_d = '0;
      pos_d = '0;
    end
  end

  // Verdict logic sees the state including the final byte.
  always_comb begin
    hdr_o = hdr_n;
    len_o = 17'(pos_q);
    if (take_i && (32'(pos_q) < MaxFrameBytes)) begin
      len_o = 17'(pos_q) + 17'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      hdr_q <= '0;
    end else begin
      pos_q <= pos_d;
      hdr_q <= hdr_d;
    end
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet classifier testbench
// Streams frames and blocklist commands into the classifier, predicts every
// verdict word in a behavioral model of the parser and compares each one
// field by field. Random idling and stalling run in phases.
// ----------------------------------------------------------------------------
module tb;
  import phpsf_pkg::*;

  localparam int unsigned TableSize = 16;
  localparam int unsigned FrameCap  = 128;
  localparam int unsigned StallCap  = 20000;

  // One predicted verdict word.
  typedef struct packed {
    outcome_e    outcome;
    logic        rule_index;
    logic [31:0] src_address;
    logic [31:0] dst_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  ip_protocol;
    logic [63:0] matched_signature;
    logic [63:0] payload_prefix;
  } verdict_t;

  // One row of the directed table: a short frame with an optional fixed answer.
  typedef struct {
    logic [7:0] first_byte;
    int         length;
    logic       has_fixed;
    outcome_e   fixed_outcome;
  } short_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] opcode_i = '0;
  logic [7:0] frame_byte_i = '0;
  logic frame_end_i = 1'b0;
  logic [31:0] table_address_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] outcome_o;
  logic rule_index_o;
  logic [31:0] src_address_o, dst_address_o;
  logic [15:0] source_port_o, dest_port_o;
  logic [7:0] ip_protocol_o;
  logic [63:0] matched_signature_o, payload_prefix_o;

  packet_header_parser_signature_filter #(.MAX_FRAME_BYTES(FrameCap)) u_dut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Predictor state: rules, blocklist and frame capture.
  logic [63:0] rule_sig [2];
  logic        rule_on [2];
  logic [31:0] block_addr [TableSize];
  logic        block_used [TableSize];
  logic [3:0]  evict_ptr;
  int unsigned pos;
  logic [3:0]  ihl, doff;
  logic [7:0]  proto;
  logic [31:0] src, dst;
  logic [15:0] sport, dport;
  logic [63:0] head;

  verdict_t verdict_q[$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic void clear_capture();
    pos = 0; ihl = '0; doff = '0; proto = '0; src = '0; dst = '0;
    sport = '0; dport = '0; head = '0;
  endfunction

  function automatic int unsigned data_offset();
    int unsigned l4;
    l4 = EthLen + 4 * ihl;
    if (proto == PROTO_TCP) return l4 + 4 * ((doff < 5) ? 5 : doff);
    if (proto == PROTO_UDP) return l4 + ((dport == DNS_PORT) ? 20 : 8);
    return 32'hFFFF_FFFF;
  endfunction

  function automatic void capture_byte(input int unsigned p, input logic [7:0] b);
    int unsigned l4, ps;
    if (p == 14) ihl = b[3:0];
    else if (p == 23) proto = b;
    else if (p >= 26 && p < 30) src = {src[23:0], b};
    else if (p >= 30 && p < 34) dst = {dst[23:0], b};
    if (ihl < MIN_IHL || p < MinIpFrame) return;
    l4 = EthLen + 4 * ihl;
    if (p == l4 || p == l4 + 1) sport = {sport[7:0], b};
    else if (p == l4 + 2 || p == l4 + 3) dport = {dport[7:0], b};
    else if (p == l4 + 12 && proto == PROTO_TCP) doff = b[7:4];
    ps = data_offset();
    if (ps != 32'hFFFF_FFFF && p >= ps && p - ps < 8)
      head |= 64'(b) << (8 * (7 - (p - ps)));
  endfunction

  function automatic verdict_t judge(input int unsigned len);
    verdict_t v;
    int unsigned need, ps, avail;
    logic hit;
    v = '0;
    v.outcome = OUT_PASS;
    if (len < MinIpFrame || ihl < MIN_IHL) return v;
    v.src_address = src; v.dst_address = dst; v.ip_protocol = proto;
    hit = 1'b0;
    for (int i = 0; i < TableSize; i++) if (block_used[i] && block_addr[i] == src) hit = 1'b1;
    if (hit) begin
      v.outcome = OUT_BLOCK;
      return v;
    end
    if (proto == PROTO_TCP) need = EthLen + 4 * ihl + 20;
    else if (proto == PROTO_UDP) need = data_offset();
    else need = 32'hFFFF_FFFF;
    if (need == 32'hFFFF_FFFF || len < need) begin
      v = '0;
      v.outcome = OUT_PASS;
      return v;
    end
    v.outcome = OUT_ACCEPT;
    v.source_port = sport; v.dest_port = dport;
    ps = data_offset();
    avail = (len > ps) ? len - ps : 0;
    if (avail == 0) return v;
    for (int i = 0; i < 2; i++) begin
      if (!rule_on[i]) continue;
      if (avail < 4) break;
      if (rule_sig[i][63:32] == head[63:32]) begin
        v.outcome = OUT_SIG; v.rule_index = 1'(i);
        v.matched_signature = rule_sig[i]; v.payload_prefix = head;
        return v;
      end
    end
    return v;
  endfunction

  function automatic void table_add(input logic [31:0] a);
    for (int i = 0; i < TableSize; i++) if (block_used[i] && block_addr[i] == a) return;
    for (int i = 0; i < TableSize; i++) if (!block_used[i]) begin
      block_addr[i] = a; block_used[i] = 1'b1;
      return;
    end
    block_addr[evict_ptr] = a;
    evict_ptr = evict_ptr + 1'b1;
  endfunction

  // Model one accepted input word.
  function automatic void predict(input opcode_e op, input logic [7:0] b, input logic e,
                                  input logic [31:0] a);
    case (op)
      OP_ADD: table_add(a);
      OP_REMOVE: begin
        for (int i = 0; i < TableSize; i++) if (block_used[i] && block_addr[i] == a)
          block_used[i] = 1'b0;
      end
      OP_BYTE: begin
        if (pos < FrameCap) begin
          capture_byte(pos, b);
          pos++;
        end
        if (e) begin
          verdict_q.push_back(judge(pos));
          clear_capture();
        end
      end
      default: ;
    endcase
  endfunction

  // Drive one word and hold it until accepted; valid stays up for the next word.
  task automatic send(input opcode_e op, input logic [7:0] b, input logic e,
                      input logic [31:0] a);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1; opcode_i <= op; frame_byte_i <= b; frame_end_i <= e;
    table_address_i <= a;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict(op, b, e, a);
    @(negedge clk_i);
  endtask

  task automatic send_frame(input logic [7:0] bytes[$]);
    foreach (bytes[i]) send(OP_BYTE, bytes[i], i == bytes.size() - 1, $urandom());
  endtask

  // Build a well formed frame with random content around valid headers.
  function automatic void build_frame(output logic [7:0] f[$], input logic [7:0] p,
                                      input int ihl_w, input int pay, input logic [31:0] s,
                                      input logic [15:0] dp, input logic [31:0] sig_word);
    int l4, hl, dw;
    f = {};
    for (int i = 0; i < 14; i++) f.push_back(8'($urandom()));
    f.push_back({4'd4, 4'(ihl_w)});
    for (int i = 15; i < 23; i++) f.push_back(8'($urandom()));
    f.push_back(p);
    f.push_back(8'($urandom())); f.push_back(8'($urandom()));
    for (int i = 3; i >= 0; i--) f.push_back(s[8*i +: 8]);
    for (int i = 0; i < 4; i++) f.push_back(8'($urandom()));
    l4 = 14 + 4 * ihl_w;
    while (f.size() < l4) f.push_back(8'($urandom()));
    f.push_back(8'($urandom())); f.push_back(8'($urandom()));
    f.push_back(dp[15:8]); f.push_back(dp[7:0]);
    // A TCP data offset under five words still occupies a 20-byte header.
    if (p == PROTO_TCP) begin
      dw = ($urandom_range(3) == 0) ? $urandom_range(15) : 5;
      hl = 4 * ((dw < 5) ? 5 : dw);
    end else begin
      dw = 0;
      hl = (dp == DNS_PORT) ? 20 : 8;
    end
    for (int i = 4; i < hl; i++)
      f.push_back((i == 12 && p == PROTO_TCP) ? 8'(dw << 4) | 8'($urandom_range(15))
                                               : 8'($urandom()));
    for (int i = 0; i < pay; i++)
      f.push_back((i < 4 && $urandom_range(1)) ? sig_word[8*(3-i) +: 8] : 8'($urandom()));
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_SIG0: rule_sig[0] = val;
      REG_ON0:  rule_on[0] = val[0];
      REG_SIG1: rule_sig[1] = val;
      REG_ON1:  rule_on[1] = val[0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Output side: random stall and field by field compare.
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) report("unexpected verdict", outcome_o, 0);
      else begin
        want = verdict_q.pop_front();
        if (outcome_o != want.outcome) report("outcome", outcome_o, want.outcome);
        if (rule_index_o != want.rule_index) report("rule_index", rule_index_o, want.rule_index);
        if (src_address_o != want.src_address)
          report("src_address", src_address_o, want.src_address);
        if (dst_address_o != want.dst_address)
          report("dst_address", dst_address_o, want.dst_address);
        if (source_port_o != want.source_port)
          report("source_port", source_port_o, want.source_port);
        if (dest_port_o != want.dest_port) report("dest_port", dest_port_o, want.dest_port);
        if (ip_protocol_o != want.ip_protocol)
          report("ip_protocol", ip_protocol_o, want.ip_protocol);
        if (matched_signature_o != want.matched_signature)
          report("matched_signature", matched_signature_o, want.matched_signature);
        if (payload_prefix_o != want.payload_prefix)
          report("payload_prefix", payload_prefix_o, want.payload_prefix);
      end
    end
  end

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  // Watchdog over cycles with no accepted word on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallCap) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    short_row_t rows[$];
    logic [7:0] f[$];
    logic [31:0] pool[$];
    logic [7:0] pr;
    int mode;
    verdict_t fixed;
    for (int i = 0; i < 2; i++) begin
      rule_sig[i] = '0; rule_on[i] = 1'b0;
    end
    for (int i = 0; i < TableSize; i++) begin
      block_addr[i] = '0; block_used[i] = 1'b0;
    end
    evict_ptr = '0;
    clear_capture();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: short and unparsed frames with fixed answers.
    rows = '{'{8'h00, 1, 1'b1, OUT_PASS}, '{8'hFF, 33, 1'b1, OUT_PASS},
             '{8'h44, 40, 1'b1, OUT_PASS}};
    foreach (rows[r]) begin
      f = {};
      for (int i = 0; i < rows[r].length; i++)
        f.push_back(i == 14 ? rows[r].first_byte : 8'($urandom()));
      fixed = '0; fixed.outcome = rows[r].fixed_outcome;
      send_frame(f);
      if (rows[r].has_fixed && verdict_q[$] != fixed) report("directed row", r, 0);
    end
    drain();
    write_reg(REG_SIG0, 64'hDEAD_BEEF_0123_4567);
    write_reg(REG_ON0, 64'd1);
    write_reg(REG_SIG1, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_ON1, 64'd1);
    // Directed: each protocol path, DNS skip, blocklist add, remove, unknown.
    build_frame(f, PROTO_TCP, 5, 8, 32'h0A000001, 16'd80, 32'hDEADBEEF); send_frame(f);
    build_frame(f, PROTO_UDP, 5, 6, 32'h0A000002, DNS_PORT, 32'hFFFFFFFF); send_frame(f);
    build_frame(f, PROTO_UDP, 15, 2, 32'h0A000003, 16'd1, 32'h0); send_frame(f);
    build_frame(f, 8'd1, 5, 4, 32'h0A000004, 16'd1, 32'h0); send_frame(f);
    send(OP_ADD, 8'h00, 1'b0, 32'h0A000001);
    send(OP_ADD, 8'h00, 1'b0, 32'h0A000001);
    build_frame(f, PROTO_TCP, 5, 8, 32'h0A000001, 16'd80, 32'hDEADBEEF); send_frame(f);
    send(OP_REMOVE, 8'h00, 1'b0, 32'h0A000001);
    send(OP_REMOVE, 8'h00, 1'b0, 32'h0A000099);
    send(OP_NONE, 8'hFF, 1'b1, 32'hFFFFFFFF);
    build_frame(f, PROTO_TCP, 5, 0, 32'hFFFFFFFF, 16'hFFFF, 32'h0); send_frame(f);
    // Long frame past the saturation point.
    f = {};
    for (int i = 0; i < FrameCap + 20; i++) f.push_back(8'($urandom()));
    f[14] = 8'h45; f[23] = PROTO_TCP;
    send_frame(f);
    drain();

    // Random phases: idling and stalling mix and rule settings change between phases.
    for (int ph = 0; ph < 8; ph++) begin
      mode = ph % 4;
      idle_pct  = (mode == 1 || mode == 3) ? (mode == 3 ? 7 : 81) : 0;
      stall_pct = (mode == 2 || mode == 3) ? (mode == 3 ? 7 : 81) : 0;
      write_reg(REG_SIG0, (ph == 4) ? 64'd0 : {$urandom(), $urandom()});
      write_reg(REG_ON0, 64'($urandom_range(1)));
      write_reg(REG_SIG1, (ph == 5) ? '1 : {$urandom(), $urandom()});
      write_reg(REG_ON1, 64'($urandom_range(1)));
      for (int k = 0; k < 4; k++) pool.push_back($urandom());
      for (int n = 0; n < 3; n++) begin
        case ($urandom_range(9))
          0: send(OP_ADD, 8'($urandom()), 1'($urandom()),
                  $urandom_range(3) ? pool[$urandom_range(pool.size()-1)] : $urandom());
          1: send(OP_REMOVE, 8'($urandom()), 1'($urandom()),
                  pool[$urandom_range(pool.size()-1)]);
          2: begin
            f = {};
            repeat ($urandom_range(1, 60)) f.push_back(8'($urandom()));
            send_frame(f);
          end
          default: begin
            pr = ($urandom_range(9) == 0) ? 8'($urandom()) :
                 ($urandom_range(1) ? PROTO_TCP : PROTO_UDP);
            build_frame(f, pr, $urandom_range(9) ? 5 : $urandom_range(5, 15),
                        $urandom_range(9) ? $urandom_range(0, 10) : $urandom_range(30),
                        ($urandom_range(2) == 0) ? pool[$urandom_range(pool.size()-1)] : $urandom(),
                        $urandom_range(2) == 0 ? DNS_PORT : 16'($urandom()),
                        rule_sig[$urandom_range(1)][63:32]);
            if ($urandom_range(7) == 0) f = f[0:$urandom_range(f.size()-1)];
            send_frame(f);
          end
        endcase
      end
      drain();
    end

    drain();
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
